### hdl/usc_pkg.sv
// Shared types, constants and calendar helper functions for the seconds/calendar converter.
`default_nettype none
package usc_pkg;

  localparam int unsigned SecondsBits = 32;
  localparam int unsigned AccW = SecondsBits + 8;

  localparam logic        FuncToDate = 1'b0;
  localparam logic        FuncToSecs = 1'b1;

  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [5:0]  SecPerMin  = 6'd60;
  localparam logic [11:0] EpochYear  = 12'd1970;
  localparam logic [6:0]  EpochMod100 = 7'd70;
  localparam logic [8:0]  EpochMod400 = 9'd370;
  localparam logic [24:0] SecPerYear     = 25'd31536000;
  localparam logic [24:0] SecPerLeapYear = 25'd31622400;

  typedef struct packed {
    logic        func;
    logic [31:0] in_seconds;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_seconds;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  out_weekday;
    logic [8:0]  out_yearday;
    logic        overflow;
  } out_item_t;

  // Length of a zero based month; February follows the leap flag.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m)
      4'd1:                      d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Seconds in a month of the given length.
  function automatic logic [21:0] month_secs(input logic [4:0] d);
    logic [21:0] s;
    unique case (d)
      5'd28:   s = 22'd2419200;
      5'd29:   s = 22'd2505600;
      5'd30:   s = 22'd2592000;
      default: s = 22'd2678400;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### hdl/unix_seconds_calendar_convert.sv
// Top level of the seconds-since-1970 to Gregorian calendar converter and its inverse.
// One request is worked at a time by a sequencer with narrow adders. Seconds to date runs a
// bit-serial division by 86400, up to 23 hour and 59 minute subtraction steps, one year
// step per year since 1970 and up to 11 month steps. Date to seconds first finds the year's
// leap status bit-serially, then steps one year at a time from 1970, takes up to 12 month
// steps, then steps once per unit of day, hour and minute.
// The result sits in an output register, so a new request is taken while it waits.
`default_nettype none
module unix_seconds_calendar_convert (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire usc_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output usc_pkg::out_item_t     out_data_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_HR0  = 4'd2;
  localparam logic [3:0] S_MN0  = 4'd3;
  localparam logic [3:0] S_YR0  = 4'd4;
  localparam logic [3:0] S_MO0  = 4'd5;
  localparam logic [3:0] S_LEAP = 4'd6;
  localparam logic [3:0] S_YR1  = 4'd7;
  localparam logic [3:0] S_MO1  = 4'd8;
  localparam logic [3:0] S_DAY1 = 4'd9;
  localparam logic [3:0] S_HR1  = 4'd10;
  localparam logic [3:0] S_MN1  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam int unsigned AccW = usc_pkg::AccW;

  logic [3:0]  state_q, state_d;
  usc_pkg::in_item_t  req_q, req_d;
  usc_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] days_q, days_d;
  logic [2:0]  wk_q, wk_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [11:0] yr_q, yr_d;
  logic [6:0]  c100_q, c100_d;
  logic [8:0]  c400_q, c400_d;
  logic [3:0]  mon_q, mon_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [6:0]  r100_q, r100_d;
  logic [8:0]  r400_q, r400_d;
  logic        leap_in_q, leap_in_d;
  logic [AccW-1:0] acc_q, acc_d;

  logic        leap_cnt, leap_mon;
  logic [8:0]  ylen;
  logic [4:0]  mdays;
  logic [17:0] div_t;
  logic [3:0]  wk_t;
  logic [7:0]  m100_t;
  logic [9:0]  m400_t;
  logic        ybit;
  logic [3:0]  mlim;
  logic        out_free;

  assign leap_cnt = (yr_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c400_q == 9'd0));
  assign leap_mon = (req_q.func == usc_pkg::FuncToSecs) ? leap_in_q : leap_cnt;
  assign ylen     = leap_cnt ? 9'd366 : 9'd365;
  assign mdays    = usc_pkg::month_days(mon_q, leap_mon);
  assign div_t    = {rem_q, num_q[31]};
  assign ybit     = req_q.in_year[cnt_q[3:0]];
  assign m100_t   = {r100_q, ybit};
  assign m400_t   = {r400_q, ybit};
  assign mlim     = (req_q.in_month > 4'd12) ? 4'd12 : req_q.in_month;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;  req_d = req_q;  res_d = res_q;
    num_d = num_q;  rem_d = rem_q;  days_d = days_q;  wk_d = wk_q;
    hour_d = hour_q;  min_d = min_q;  yr_d = yr_q;  c100_d = c100_q;  c400_d = c400_q;
    mon_d = mon_q;  cnt_d = cnt_q;  r100_d = r100_q;  r400_d = r400_q;
    leap_in_d = leap_in_q;  acc_d = acc_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wk_t = 4'd0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          res_d  = '0;
          num_d  = in_data_i.in_seconds;
          rem_d  = '0;  days_d = '0;  wk_d = '0;  hour_d = '0;  min_d = '0;
          yr_d   = usc_pkg::EpochYear;
          c100_d = usc_pkg::EpochMod100;
          c400_d = usc_pkg::EpochMod400;
          mon_d  = '0;
          r100_d = '0;  r400_d = '0;
          acc_d  = AccW'(0) - AccW'(usc_pkg::SecPerDay);
          if (in_data_i.func == usc_pkg::FuncToDate) begin
            cnt_d   = 6'd31;
            state_d = S_DIV;
          end else begin
            cnt_d   = 6'd11;
            state_d = S_LEAP;
          end
        end
      end
      S_DIV: begin
        // Restoring division by 86400, one quotient bit per cycle, with the
        // quotient folded modulo 7 on the fly for the weekday.
        num_d = {num_q[30:0], 1'b0};
        if (div_t >= 18'(usc_pkg::SecPerDay)) begin
          rem_d  = 17'(div_t - 18'(usc_pkg::SecPerDay));
          days_d = {days_q[14:0], 1'b1};
          wk_t   = {wk_q, 1'b1};
        end else begin
          rem_d  = div_t[16:0];
          days_d = {days_q[14:0], 1'b0};
          wk_t   = {wk_q, 1'b0};
        end
        wk_d = (wk_t >= 4'd7) ? 3'(wk_t - 4'd7) : wk_t[2:0];
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          state_d = S_HR0;
        end
      end
      S_HR0: begin
        if (rem_q >= 17'(usc_pkg::SecPerHour)) begin
          rem_d  = rem_q - 17'(usc_pkg::SecPerHour);
          hour_d = hour_q + 5'd1;
        end else begin
          state_d = S_MN0;
        end
      end
      S_MN0: begin
        if (rem_q >= 17'(usc_pkg::SecPerMin)) begin
          rem_d = rem_q - 17'(usc_pkg::SecPerMin);
          min_d = min_q + 6'd1;
        end else begin
          state_d = S_YR0;
        end
      end
      S_YR0: begin
        if (days_q >= 16'(ylen)) begin
          days_d = days_q - 16'(ylen);
          yr_d   = yr_q + 12'd1;
          c100_d = (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
          c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        end else begin
          res_d.out_yearday = days_q[8:0];
          state_d = S_MO0;
        end
      end
      S_MO0: begin
        if ((mon_q < 4'd11) && (days_q >= 16'(mdays))) begin
          days_d = days_q - 16'(mdays);
          mon_d  = mon_q + 4'd1;
        end else begin
          res_d.out_year    = yr_q;
          res_d.out_month   = mon_q;
          res_d.out_day     = 5'(days_q + 16'd1);
          res_d.out_hour    = hour_q;
          res_d.out_minute  = min_q;
          res_d.out_second  = rem_q[5:0];
          res_d.out_weekday = (wk_q >= 3'd3) ? 3'(wk_q - 3'd3) : 3'(wk_q + 3'd4);
          state_d = S_DONE;
        end
      end
      S_LEAP: begin
        // Year modulo 100 and 400, one year bit per cycle, most significant first.
        r100_d = (m100_t >= 8'd100) ? 7'(m100_t - 8'd100) : m100_t[6:0];
        r400_d = (m400_t >= 10'd400) ? 9'(m400_t - 10'd400) : m400_t[8:0];
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          state_d = S_YR1;
        end
      end
      S_YR1: begin
        leap_in_d = (req_q.in_year[1:0] == 2'd0) && ((r100_q != 7'd0) || (r400_q == 9'd0));
        if (yr_q < req_q.in_year) begin
          acc_d  = acc_q + AccW'(leap_cnt ? usc_pkg::SecPerLeapYear : usc_pkg::SecPerYear);
          yr_d   = yr_q + 12'd1;
          c100_d = (c100_q == 7'd99) ? 7'd0 : c100_q + 7'd1;
          c400_d = (c400_q == 9'd399) ? 9'd0 : c400_q + 9'd1;
        end else begin
          state_d = S_MO1;
        end
      end
      S_MO1: begin
        if (mon_q < mlim) begin
          acc_d = acc_q + AccW'(usc_pkg::month_secs(mdays));
          mon_d = mon_q + 4'd1;
        end else begin
          cnt_d   = 6'(req_q.in_day);
          state_d = S_DAY1;
        end
      end
      S_DAY1: begin
        if (cnt_q != 6'd0) begin
          acc_d = acc_q + AccW'(usc_pkg::SecPerDay);
          cnt_d = cnt_q - 6'd1;
        end else begin
          cnt_d   = 6'(req_q.in_hour);
          state_d = S_HR1;
        end
      end
      S_HR1: begin
        if (cnt_q != 6'd0) begin
          acc_d = acc_q + AccW'(usc_pkg::SecPerHour);
          cnt_d = cnt_q - 6'd1;
        end else begin
          cnt_d   = req_q.in_minute;
          state_d = S_MN1;
        end
      end
      S_MN1: begin
        if (cnt_q != 6'd0) begin
          acc_d = acc_q + AccW'(usc_pkg::SecPerMin);
          cnt_d = cnt_q - 6'd1;
        end else begin
          acc_d = acc_q + AccW'(req_q.in_second);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d = res_q;
          if (req_q.func == usc_pkg::FuncToSecs) begin
            out_d.out_seconds = acc_q[31:0];
            // A negative total also lands here through its sign bits.
            out_d.overflow    = |acc_q[AccW-1:usc_pkg::SecondsBits];
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;  res_q <= res_d;  out_q <= out_d;
    num_q <= num_d;  rem_q <= rem_d;  days_q <= days_d;  wk_q <= wk_d;
    hour_q <= hour_d;  min_q <= min_d;  yr_q <= yr_d;  c100_q <= c100_d;  c400_q <= c400_d;
    mon_q <= mon_d;  cnt_q <= cnt_d;  r100_q <= r100_d;  r400_q <= r400_d;
    leap_in_q <= leap_in_d;  acc_q <= acc_d;
  end

  a_rem_below_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HR0) |-> (rem_q < 17'(usc_pkg::SecPerDay)))
    else $error("remainder of day division out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MO0) |-> (mon_q <= 4'd11))
    else $error("month walk ran past December");

  a_date_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |-> (out_data_o.out_year == 12'd0))
    else $error("overflow set on a date result");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && out_free) |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("finished result not transferred to output register");

endmodule
`default_nettype wire

### dv/unix_seconds_calendar_convert_tb.sv
// Testbench for the seconds/calendar converter: random and directed requests, scoreboard check.
`default_nettype none
module unix_seconds_calendar_convert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1330;
  localparam int StallLimit = 20000;

  // Predicts one result per request and checks results in order.
  class calendar_scoreboard;
    usc_pkg::out_item_t pending_q[$];
    int errors;

    function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned month_length(int unsigned y, int unsigned m);
      int unsigned lens[12];
      lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 1 && is_leap(y)) return 29;
      return lens[m % 12];
    endfunction

    function usc_pkg::out_item_t convert(usc_pkg::in_item_t req);
      usc_pkg::out_item_t r;
      longint unsigned days, rem, ylen;
      longint signed sdays, total;
      longint unsigned bits;
      int unsigned yr, mon, mlim;
      r = '0;
      if (req.func == usc_pkg::FuncToDate) begin
        days = req.in_seconds / 86400;
        rem = req.in_seconds % 86400;
        r.out_hour = 5'(rem / 3600);
        r.out_minute = 6'((rem % 3600) / 60);
        r.out_second = 6'(rem % 60);
        r.out_weekday = 3'((days + 4) % 7);
        yr = 1970;
        forever begin
          ylen = is_leap(yr) ? 366 : 365;
          if (days < ylen) break;
          days -= ylen;
          yr++;
        end
        r.out_yearday = 9'(days);
        mon = 0;
        while (mon < 11 && days >= month_length(yr, mon)) begin
          days -= month_length(yr, mon);
          mon++;
        end
        r.out_year = 12'(yr);
        r.out_month = 4'(mon);
        r.out_day = 5'(days + 1);
      end else begin
        sdays = 0;
        for (int unsigned y = 1970; y < req.in_year; y++) sdays += is_leap(y) ? 366 : 365;
        mlim = (req.in_month > 12) ? 12 : req.in_month;
        for (int unsigned m = 0; m < mlim; m++) sdays += month_length(req.in_year, m);
        sdays += longint'(req.in_day) - 1;
        total = sdays * 86400 + longint'(req.in_hour) * 3600
              + longint'(req.in_minute) * 60 + longint'(req.in_second);
        bits = total;
        r.overflow = (total < 0) || (bits > 64'hFFFF_FFFF);
        r.out_seconds = bits[31:0];
      end
      return r;
    endfunction

    function void note_request(usc_pkg::in_item_t req);
      pending_q.push_back(convert(req));
    endfunction

    function void check_result(usc_pkg::out_item_t got);
      usc_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  usc_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  usc_pkg::out_item_t out_data_o;

  calendar_scoreboard board = new();
  bit sending_done = 1'b0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;
  usc_pkg::in_item_t directed_q[$];

  always #1 clk_i = ~clk_i;

  unix_seconds_calendar_convert uut (.*);

  function automatic usc_pkg::in_item_t date_request(int unsigned y, int unsigned mo,
                                                     int unsigned d, int unsigned h,
                                                     int unsigned mi, int unsigned s);
    usc_pkg::in_item_t req;
    req = '0;
    req.func = usc_pkg::FuncToSecs;
    req.in_year = 12'(y); req.in_month = 4'(mo); req.in_day = 5'(d);
    req.in_hour = 5'(h); req.in_minute = 6'(mi); req.in_second = 6'(s);
    req.in_seconds = $urandom;
    return req;
  endfunction

  function automatic usc_pkg::in_item_t secs_request(logic [31:0] s);
    usc_pkg::in_item_t req;
    req = usc_pkg::in_item_t'({$urandom, $urandom});
    req.func = usc_pkg::FuncToDate;
    req.in_seconds = s;
    return req;
  endfunction

  function automatic usc_pkg::in_item_t random_request();
    usc_pkg::in_item_t req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req = secs_request(pick < 5 ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom);
    end else if (pick < 90) begin
      req = date_request($urandom_range(1970, 2106), $urandom_range(0, 11),
                         $urandom_range(1, 31), $urandom_range(0, 23),
                         $urandom_range(0, 59), $urandom_range(0, 59));
    end else begin
      // Fields outside their usual ranges, most years kept small so the walk stays short.
      req = usc_pkg::in_item_t'({$urandom, $urandom});
      req.func = usc_pkg::FuncToSecs;
      if (pick < 96) req.in_year = 12'($urandom_range(0, 2200));
    end
    return req;
  endfunction

  task automatic send(usc_pkg::in_item_t req);
    if (!calm && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(0, 99) < 38);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(req);
  endtask

  initial begin
    directed_q.push_back(secs_request(32'd0));
    directed_q.push_back(secs_request(32'hFFFF_FFFF));
    directed_q.push_back(secs_request(32'd951782400));   // leap day 2000
    directed_q.push_back(secs_request(32'd4107542399));  // end of February 2100
    directed_q.push_back(secs_request(32'd86399));
    directed_q.push_back(date_request(1970, 0, 1, 0, 0, 0));
    directed_q.push_back(date_request(2106, 1, 7, 6, 28, 15));
    directed_q.push_back(date_request(2106, 1, 7, 6, 28, 16));   // just past the top
    directed_q.push_back(date_request(2106, 11, 31, 23, 59, 59));
    directed_q.push_back(date_request(2000, 1, 29, 12, 0, 0));
    directed_q.push_back(date_request(2100, 1, 31, 0, 0, 0));    // day past month end
    directed_q.push_back(date_request(1969, 5, 10, 1, 2, 3));    // year before epoch
    directed_q.push_back(date_request(0, 1, 31, 0, 0, 0));
    directed_q.push_back(date_request(1999, 12, 1, 0, 0, 0));    // month out of range
    directed_q.push_back(date_request(2004, 15, 1, 0, 0, 0));
    directed_q.push_back(date_request(1970, 0, 0, 0, 0, 0));     // day zero, negative
    directed_q.push_back(date_request(1990, 3, 0, 5, 6, 7));
    directed_q.push_back(date_request(2020, 6, 15, 31, 63, 63)); // time out of range
    directed_q.push_back(date_request(2300, 11, 31, 31, 63, 63));
    directed_q.push_back(date_request(4095, 15, 31, 31, 63, 63));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_q[i]) send(directed_q[i]);
    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 400 && i < 550);
      hold_off = (i >= 700 && i < 720);
      send(random_request());
    end
    in_valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (600) @(posedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_off);
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 38);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (sending_done && board.pending_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (board.errors == 0) $display("unix_seconds_calendar_convert_tb OK");
    else $display("unix_seconds_calendar_convert_tb NOT OK");
    $finish;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("unix_seconds_calendar_convert_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
hdl/usc_pkg.sv
hdl/unix_seconds_calendar_convert.sv
dv/unix_seconds_calendar_convert_tb.sv
